// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define BST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// implication form built on the macro above
`define BST_ASSERT_IMP(lbl, ante, cons) \
  `BST_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== rtl/bst_pkg.sv =====
// types, codes and constants of the bencode stream tokenizer
package bst_pkg;

  localparam int MAX_DEPTH_DEF = 32;

  // raw byte codes
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] LEN_LIMIT = 64'h0000_0000_7FFF_FFFF;

  // event codes
  typedef enum logic [2:0] {
    EV_PENDING = 3'd0,
    EV_INT     = 3'd1,
    EV_SHDR    = 3'd2,
    EV_SBYTE   = 3'd3,
    EV_LOPEN   = 3'd4,
    EV_DOPEN   = 3'd5,
    EV_CLOSE   = 3'd6,
    EV_ERROR   = 3'd7
  } ev_t;

  // container kinds held on the stack
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIST = 2'd1,
    KIND_DKEY = 2'd2,
    KIND_DVAL = 2'd3
  } kind_t;

  // parser phases
  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_INT_START  = 5'b00010,
    PH_INT_DIGITS = 5'b00100,
    PH_STR_LEN    = 5'b01000,
    PH_STR_BODY   = 5'b10000
  } phase_t;

  // one result item
  typedef struct packed {
    ev_t         ev;
    logic [63:0] val;
    logic [5:0]  nest;
    logic        key;
    logic        last;
  } res_t;

endpackage

// ===== rtl/bencode_stream_tokenizer_unit.sv =====
// bencode stream tokenizer top level: byte parser, stack memory and output buffer
//
//  channel | dir | payload                                   | handshake
//  in_     | in  | tdata[7:0] byte                           | tvalid/tready
//  out_    | out | tdata value/nest, tuser event/key, tlast   | tvalid/tready
//
// one byte per cycle, one result item per byte; a result is registered in the parser
// result register, then in the output buffer, before it can be taken
// the stack top sits in a register; the entry below it is always prefetched
// from the one-read one-write stack memory, so a close never waits
// synchronous active-low reset; the stack memory needs no clearing
// input stalls only when the parser result register waits on a full output buffer
module bencode_stream_tokenizer_unit
  import bst_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] token_value, [69:64] nest_level, zero fill
  output logic [3:0]  out_tuser,  // [2:0] event_res, [3] is_dict_key
  output logic        out_tlast   // last_of_string
);

  localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SPW = $clog2(MAX_DEPTH + 1);

  // parser state
  phase_t         phase_r, phase_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic           neg_r, neg_nxt;
  logic [30:0]    rem_r, rem_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  kind_t          top_r, top_nxt;
  logic           err_r, err_nxt;

  // result register toward the output buffer
  res_t           res_r, res;
  logic           res_vld_r;
  logic           buf_ready;

  // stack memory port
  logic           mem_we;
  kind_t          mem_wdata;
  kind_t          below;

  // helpers
  logic           acc_in;
  logic           is_dig;
  logic [3:0]     dig;
  kind_t          tk, tflip;
  logic [35:0]    len10;
  logic [63:0]    int10;
  logic [30:0]    rem_dec;
  res_t           out_res;

  assign in_tready = buf_ready || !res_vld_r;
  assign acc_in    = in_tvalid && in_tready;
  assign is_dig    = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign dig       = in_tdata[3:0];
  assign tk        = (sp_r == '0) ? KIND_NONE : top_r;
  assign len10     = {1'b0, acc_r[31:0], 3'b000} + {3'b000, acc_r[31:0], 1'b0}
                     + {32'd0, dig};
  assign int10     = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + {60'd0, dig};
  assign rem_dec   = rem_r - {30'd0, (rem_r != '0)};

  // key/value flip of the enclosing dictionary when an item starts
  always_comb begin
    unique case (tk)
      KIND_DKEY: tflip = KIND_DVAL;
      KIND_DVAL: tflip = KIND_DKEY;
      default:   tflip = tk;
    endcase
  end

  // per-byte parse step
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    sp_nxt    = sp_r;
    top_nxt   = top_r;
    err_nxt   = err_r;
    mem_we    = 1'b0;
    mem_wdata = tflip;
    res.ev    = EV_ERROR;
    res.val   = '0;
    res.key   = 1'b0;
    res.last  = 1'b0;
    if (acc_in && !err_r) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_tdata == CH_I) begin
            if (tk != KIND_DKEY) begin
              top_nxt   = tflip;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              phase_nxt = PH_INT_START;
              res.ev    = EV_PENDING;
            end
          end else if (in_tdata == CH_L || in_tdata == CH_D) begin
            if (tk != KIND_DKEY && sp_r < SPW'(MAX_DEPTH)) begin
              // old top, flipped, goes down into the memory
              mem_we  = (sp_r != '0);
              top_nxt = (in_tdata == CH_L) ? KIND_LIST : KIND_DKEY;
              sp_nxt  = sp_r + SPW'(1);
              res.ev  = (in_tdata == CH_L) ? EV_LOPEN : EV_DOPEN;
            end
          end else if (in_tdata == CH_E) begin
            if (sp_r != '0 && tk != KIND_DVAL) begin
              sp_nxt  = sp_r - SPW'(1);
              top_nxt = below;
              res.ev  = EV_CLOSE;
            end
          end else if (is_dig) begin
            top_nxt   = tflip;
            acc_nxt   = {60'd0, dig};
            phase_nxt = PH_STR_LEN;
            res.ev    = EV_PENDING;
          end
        end
        PH_INT_START, PH_INT_DIGITS: begin
          if (in_tdata == CH_E) begin
            res.val   = neg_r ? (64'd0 - acc_r) : acc_r;
            phase_nxt = PH_IDLE;
            res.ev    = EV_INT;
          end else if (in_tdata == CH_MINUS && phase_r == PH_INT_START) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_INT_DIGITS;
            res.ev    = EV_PENDING;
          end else if (is_dig) begin
            acc_nxt   = int10;
            phase_nxt = PH_INT_DIGITS;
            res.ev    = EV_PENDING;
          end
        end
        PH_STR_LEN: begin
          if (is_dig) begin
            // saturate just above the length limit
            acc_nxt = ({28'd0, len10} > LEN_LIMIT) ? (LEN_LIMIT + 64'd1)
                                                   : {28'd0, len10};
            res.ev  = EV_PENDING;
          end else if (in_tdata == CH_COLON && acc_r <= LEN_LIMIT) begin
            res.val   = acc_r;
            res.key   = (tk == KIND_DVAL);
            rem_nxt   = acc_r[30:0];
            res.last  = (acc_r == '0);
            phase_nxt = (acc_r == '0) ? PH_IDLE : PH_STR_BODY;
            res.ev    = EV_SHDR;
          end
        end
        PH_STR_BODY: begin
          res.val  = {56'd0, in_tdata};
          res.key  = (tk == KIND_DVAL);
          rem_nxt  = rem_dec;
          res.last = (rem_dec == '0);
          if (rem_dec == '0) phase_nxt = PH_IDLE;
          res.ev   = EV_SBYTE;
        end
        default: begin
        end
      endcase
    end
    // any failure is sticky
    if (res.ev == EV_ERROR) begin
      if (acc_in) err_nxt = 1'b1;
      res.val  = '0;
      res.key  = 1'b0;
      res.last = 1'b0;
    end
    res.nest = 6'(sp_nxt);
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      acc_r     <= '0;
      neg_r     <= 1'b0;
      rem_r     <= '0;
      sp_r      <= '0;
      top_r     <= KIND_NONE;
      err_r     <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      rem_r   <= rem_nxt;
      sp_r    <= sp_nxt;
      top_r   <= top_nxt;
      err_r   <= err_nxt;
      if (in_tready) res_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      res_r <= res;
    end
  end

  // stack memory: write the old top at push, prefetch the entry below the new top
  bst_stack_mem #(
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (AW'(sp_r - SPW'(1))),
    .wdata (mem_wdata),
    .raddr (AW'(sp_nxt - SPW'(2))),
    .rdata (below)
  );

  // output buffer
  bst_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_vld_r),
    .in_ready  (buf_ready),
    .in_res    (res_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.nest, out_res.val};
  assign out_tuser = {out_res.key, out_res.ev};
  assign out_tlast = out_res.last;

endmodule

// ===== rtl/bst_stack_mem.sv =====
// container stack memory with registered read and write-to-read forwarding
module bst_stack_mem
  import bst_pkg::*;
#(
  parameter int DEPTH = MAX_DEPTH_DEF,
  parameter int AW    = $clog2(MAX_DEPTH_DEF)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  kind_t         wdata,
  input  logic [AW-1:0] raddr,
  output kind_t         rdata
);

  kind_t         mem [DEPTH];
  kind_t         q_r;
  kind_t         fwd_data_r;
  logic          fwd_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    q_r        <= mem[raddr];
    fwd_data_r <= wdata;
  end

  // same-entry write and read in one cycle: take the written kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd_r ? fwd_data_r : q_r;

endmodule

// ===== rtl/bst_out_buf.sv =====
// two-entry output buffer parting the parser from the result channel
module bst_out_buf
  import bst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  res_t       buf_r [2];
  logic       head_r, tail_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = buf_r[head_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // occupancy
  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[tail_r] <= in_res;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) tail_r <= ~tail_r;
      if (pop)  head_r <= ~head_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/bst_checker.sv =====
// port-level checker for the tokenizer, bound to the top level
`include "assert_macros.svh"

module bst_checker
  import bst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  logic       out_acc;
  logic [2:0] ev;
  logic [5:0] nest;
  logic [5:0] prev_nest_r;
  logic       seen_err_r;
  logic       opens;
  logic       keep_ok;

  assign out_acc = out_tvalid && out_tready;
  assign ev      = out_tuser[2:0];
  assign nest    = out_tdata[69:64];
  assign opens   = (ev == EV_LOPEN) || (ev == EV_DOPEN);
  assign keep_ok = (ev == EV_CLOSE) ? (nest + 6'd1 == prev_nest_r) : (nest == prev_nest_r);

  // depth of the last delivered item and whether an error went out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nest_r <= '0;
      seen_err_r  <= 1'b0;
    end else if (out_acc) begin
      prev_nest_r <= nest;
      if (ev == EV_ERROR) seen_err_r <= 1'b1;
    end
  end

  // a waiting result stays offered
  `BST_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid)

  // after an error item every later item is an error
  `BST_ASSERT_IMP(a_err_sticky, out_acc && seen_err_r, ev == EV_ERROR)

  // an open goes one level deeper than the item before it
  `BST_ASSERT_IMP(a_open_depth, out_acc && opens, nest == prev_nest_r + 6'd1)

  // a close goes one level up; other items keep the depth
  `BST_ASSERT_IMP(a_keep_depth, out_acc && !opens, keep_ok)

  // last flag only on string items
  `BST_ASSERT_IMP(a_last_str, out_acc && out_tlast, ev == EV_SHDR || ev == EV_SBYTE)

endmodule

bind bencode_stream_tokenizer_unit bst_checker u_bst_checker (.*);

// ===== bench/token_event_checker.sv =====
// event checker for the bencode stream tokenizer: byte parser model and result compare
module token_event_checker
  import bst_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,   // [63:0] token_value, [69:64] nest_level, zero fill
  input  logic [3:0]  out_tuser,   // [2:0] event_res, [3] is_dict_key
  input  logic        out_tlast,   // last_of_string
  output int unsigned mismatch_count,
  output int unsigned events_owed
);

  // parser state
  phase_t      phase;
  logic [63:0] acc;
  logic        neg;
  logic [30:0] remaining;
  kind_t       kind_stack [MAX_DEPTH];
  int          open_depth;
  logic        faulted;

  res_t expected_events [$];
  res_t want;
  res_t got;

  // an item starts inside the current container: swap key and value
  task automatic flip_top();
    if (open_depth > 0) begin
      if (kind_stack[open_depth-1] == KIND_DKEY) kind_stack[open_depth-1] = KIND_DVAL;
      else if (kind_stack[open_depth-1] == KIND_DVAL) kind_stack[open_depth-1] = KIND_DKEY;
    end
  endtask

  // advance the parser by one byte and form the event it answers
  task automatic parse_byte(input logic [7:0] b, output res_t r);
    ev_t         ev;
    logic [63:0] val;
    logic [63:0] n;
    logic        key;
    logic        last;
    kind_t       tk;
    logic        dig;
    ev   = EV_ERROR;
    val  = '0;
    key  = 1'b0;
    last = 1'b0;
    tk   = (open_depth == 0) ? KIND_NONE : kind_stack[open_depth-1];
    dig  = (b >= CH_ZERO) && (b <= CH_NINE);
    if (!faulted) begin
      case (phase)
        PH_IDLE: begin
          if (b == CH_I || b == CH_L || b == CH_D) begin
            // a dictionary key must be a string
            if (tk != KIND_DKEY) begin
              if (b == CH_I) begin
                flip_top();
                acc   = '0;
                neg   = 1'b0;
                phase = PH_INT_START;
                ev    = EV_PENDING;
              end else if (open_depth < MAX_DEPTH) begin
                flip_top();
                kind_stack[open_depth] = (b == CH_L) ? KIND_LIST : KIND_DKEY;
                open_depth++;
                ev = (b == CH_L) ? EV_LOPEN : EV_DOPEN;
              end
            end
          end else if (b == CH_E) begin
            if (open_depth != 0 && tk != KIND_DVAL) begin
              open_depth--;
              ev = EV_CLOSE;
            end
          end else if (dig) begin
            flip_top();
            acc   = 64'(b - CH_ZERO);
            phase = PH_STR_LEN;
            ev    = EV_PENDING;
          end
        end
        PH_INT_START, PH_INT_DIGITS: begin
          if (b == CH_E) begin
            val   = neg ? (64'd0 - acc) : acc;
            phase = PH_IDLE;
            ev    = EV_INT;
          end else if (b == CH_MINUS && phase == PH_INT_START) begin
            neg   = 1'b1;
            phase = PH_INT_DIGITS;
            ev    = EV_PENDING;
          end else if (dig) begin
            acc   = acc * 64'd10 + 64'(b - CH_ZERO);
            phase = PH_INT_DIGITS;
            ev    = EV_PENDING;
          end
        end
        PH_STR_LEN: begin
          if (dig) begin
            // length saturates just above the limit
            n   = acc * 64'd10 + 64'(b - CH_ZERO);
            acc = (n > LEN_LIMIT) ? LEN_LIMIT + 64'd1 : n;
            ev  = EV_PENDING;
          end else if (b == CH_COLON && acc <= LEN_LIMIT) begin
            val       = acc;
            key       = (tk == KIND_DVAL);
            remaining = acc[30:0];
            last      = (acc[30:0] == '0);
            phase     = last ? PH_IDLE : PH_STR_BODY;
            ev        = EV_SHDR;
          end
        end
        PH_STR_BODY: begin
          val = {56'd0, b};
          key = (tk == KIND_DVAL);
          if (remaining != '0) remaining = remaining - 31'd1;
          last = (remaining == '0);
          if (last) phase = PH_IDLE;
          ev = EV_SBYTE;
        end
        default: ;
      endcase
    end
    // errors stick until reset
    if (ev == EV_ERROR) begin
      faulted = 1'b1;
      val     = '0;
      key     = 1'b0;
      last    = 1'b0;
    end
    r.ev   = ev;
    r.val  = val;
    r.nest = open_depth[5:0];
    r.key  = key;
    r.last = last;
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = PH_IDLE;
      acc        = '0;
      neg        = 1'b0;
      remaining  = '0;
      open_depth = 0;
      faulted    = 1'b0;
      expected_events.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, want);
        expected_events.insert(expected_events.size(), want);
      end
      if (out_tvalid && out_tready) begin
        got.ev   = ev_t'(out_tuser[2:0]);
        got.val  = out_tdata[63:0];
        got.nest = out_tdata[69:64];
        got.key  = out_tuser[3];
        got.last = out_tlast;
        if (expected_events.size() == 0) begin
          $error("result item with no event expected");
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          if (got.ev !== want.ev) begin
            $error("event_res: expected %0d, actual %0d", want.ev, got.ev);
            mismatch_count++;
          end
          if (got.val !== want.val) begin
            $error("token_value: expected %0d, actual %0d",
                   $signed(want.val), $signed(got.val));
            mismatch_count++;
          end
          if (got.nest !== want.nest) begin
            $error("nest_level: expected %0d, actual %0d", want.nest, got.nest);
            mismatch_count++;
          end
          if (got.key !== want.key) begin
            $error("is_dict_key: expected %0d, actual %0d", want.key, got.key);
            mismatch_count++;
          end
          if (got.last !== want.last) begin
            $error("last_of_string: expected %0d, actual %0d", want.last, got.last);
            mismatch_count++;
          end
        end
      end
    end
    events_owed <= expected_events.size();
  end

endmodule

// ===== bench/tb_bencode_stream_tokenizer_unit.sv =====
// testbench top for the bencode stream tokenizer: byte stream stimulus and verdict
module tb_bencode_stream_tokenizer_unit
  import bst_pkg::*;
();

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  int unsigned mismatch_count;
  int unsigned events_owed;

  logic [7:0] byte_stream [$];

  always #4 clk = ~clk;

  bencode_stream_tokenizer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  token_event_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .events_owed    (events_owed)
  );

  function automatic bit is_digit_byte(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // append one byte to the stream
  task automatic put_byte(input logic [7:0] b);
    byte_stream.insert(byte_stream.size(), b);
  endtask

  task automatic put_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) put_byte(s[k]);
  endtask

  // integer with optional sign, leading zeros and now and then enough digits to wrap
  task automatic put_int();
    int n;
    int k;
    put_byte(CH_I);
    if ($urandom_range(0, 3) == 0) put_byte(CH_MINUS);
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = $urandom_range(15, 25);
      default: n = $urandom_range(1, 5);
    endcase
    for (k = 0; k < n; k++) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    put_byte(CH_E);
  endtask

  // string with a random body of any byte values, now and then with a leading zero on its length
  task automatic put_string();
    int n;
    int k;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) put_byte(CH_ZERO);
    put_text($sformatf("%0d:", n));
    for (k = 0; k < n; k++) put_byte(8'($urandom_range(0, 255)));
  endtask

  // one well-formed value, containers nested up to lim deep
  task automatic put_doc(input int lim, input int cont_pct, input int lo, input int hi);
    bit is_dict [64];
    int left [64];
    int d;
    bit need;
    d    = 0;
    need = 1'b1;
    while (need || d > 0) begin
      if (need) begin
        need = 1'b0;
        if (d < lim && $urandom_range(1, 100) <= cont_pct) begin
          is_dict[d] = $urandom_range(0, 1);
          left[d]    = $urandom_range(lo, hi);
          put_byte(is_dict[d] ? CH_D : CH_L);
          d++;
        end else if ($urandom_range(0, 1)) begin
          put_int();
        end else begin
          put_string();
        end
      end else if (left[d-1] == 0) begin
        put_byte(CH_E);
        d--;
      end else begin
        left[d-1]--;
        if (is_dict[d-1]) put_string();
        need = 1'b1;
      end
    end
  endtask

  // closing sequence: one broken case, or a string too long to finish
  task automatic put_tail();
    logic [7:0] b;
    int k;
    int pick;
    pick = $urandom_range(0, 8);
    case (pick)
      // non-string key
      0: begin
        put_byte(CH_D);
        case ($urandom_range(0, 2))
          0: put_byte(CH_I);
          1: put_byte(CH_L);
          default: put_byte(CH_D);
        endcase
      end
      // close with the value missing
      1: put_text("d1:ke");
      // close with nothing open
      2: put_byte(CH_E);
      // one level past the stack
      3: begin
        for (k = 0; k < MAX_DEPTH_DEF; k++) put_byte(CH_L);
        put_byte($urandom_range(0, 1) ? CH_L : CH_D);
      end
      // byte that cannot start an item
      4: begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_I || b == CH_L || b == CH_D || b == CH_E || is_digit_byte(b));
        put_byte(b);
      end
      // missing colon after the length
      5: begin
        put_text("12");
        do b = 8'($urandom_range(0, 255));
        while (b == CH_COLON || is_digit_byte(b));
        put_byte(b);
      end
      // stray byte inside an integer
      6: begin
        if ($urandom_range(0, 1)) begin
          put_text("i1-");
        end else begin
          put_text("i12");
          do b = 8'($urandom_range(0, 255));
          while (b == CH_E || is_digit_byte(b));
          put_byte(b);
        end
      end
      // length over the limit
      7: begin
        if ($urandom_range(0, 1)) put_text("2147483648:");
        else put_text("99999999999:");
      end
      // largest legal length, body never completes
      default: put_text("2147483647:");
    endcase
    // trailing bytes: noise after an error, body bytes otherwise
    for (k = 0; k < 30; k++) put_byte(8'($urandom_range(0, 255)));
  endtask

  // stimulus, reset and verdict
  initial begin : feed
    int gap;
    int sent;
    int pick;
    bit fast;
    // short directed run: loose integers, empty and one-byte strings, empty containers
    put_text("iei-ei-0ei007e0:1:edei0ele");
    while (byte_stream.size() < 1040) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        put_doc(4, 35, 0, 4);
      end else if (pick < 85) begin
        put_doc(($urandom_range(0, 3) == 0) ? MAX_DEPTH_DEF : $urandom_range(1, MAX_DEPTH_DEF),
                100, 1, 1);
      end else begin
        put_doc(0, 0, 0, 0);
      end
    end
    put_tail();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    sent = 0;
    fast = 1'b0;
    while (sent < byte_stream.size()) begin
      if (sent % 90 == 0) fast = ($urandom_range(0, 3) == 0);
      gap = fast ? 0 : $urandom_range(0, 13);
      // drain everything once mid-run
      if (sent == 600) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (events_owed != 0);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= byte_stream[sent];
      do @(posedge clk); while (!in_tready);
      sent++;
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (events_owed != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side: random stalls, bursts and one long hold-off
  initial begin : drain
    int gap;
    int taken;
    bit fast;
    taken = 0;
    fast  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 100 == 0) fast = ($urandom_range(0, 3) == 0);
      gap = fast ? 0 : $urandom_range(0, 13);
      if (taken == 300) gap = 250;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bst_pkg.sv
rtl/bst_stack_mem.sv
rtl/bst_out_buf.sv
rtl/bencode_stream_tokenizer_unit.sv
rtl/bst_checker.sv
bench/token_event_checker.sv
bench/tb_bencode_stream_tokenizer_unit.sv
